FILE: rtl/core/tpct_pkg.sv
package tpct_pkg;

    localparam int TABLE_ENTRIES_DEF = 64;
    localparam int QUEUE_DEPTH_DEF   = 2;

    localparam logic [15:0] ETHERTYPE_IPV4 = 16'd2048;
    localparam logic [7:0]  PROTOCOL_TCP   = 8'd6;
    localparam logic [31:0] PACKETS_MAX    = 32'hFFFF_FFFF;
    localparam logic [47:0] BYTES_MAX      = 48'hFFFF_FFFF_FFFF;

    typedef struct packed {
        logic [15:0] ether_type;
        logic [7:0]  ip_protocol;
        logic [15:0] source_port;
        logic [15:0] dest_port;
        logic [17:0] captured_bytes;
        logic        last_packet;
    } packet_t;

    typedef struct packed {
        logic [5:0]  conv_index;
        logic        new_conversation;
        logic        table_full;
        logic [31:0] conv_packets;
        logic [47:0] conv_bytes;
        logic [6:0]  conversation_count;
    } result_t;

    // classified packet as it waits between front and back
    typedef struct packed {
        logic        is_tcp;
        logic [15:0] source_port;
        logic [15:0] dest_port;
        logic [17:0] captured_bytes;
        logic        last_packet;
    } queue_item_t;

    typedef struct packed {
        logic full;
        logic empty;
    } queue_status_t;

    typedef struct packed {
        logic        is_tcp;
        logic [15:0] src_port;
        logic [15:0] dst_port;
        logic [31:0] packets;
        logic [47:0] bytes;
    } entry_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_COMMIT
    } state_t;

endpackage

FILE: rtl/core/tpct_front.sv
module tpct_front (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    packet_valid,
    output logic                    packet_ready,
    input  tpct_pkg::packet_t       packet,
    output logic                    push,
    output tpct_pkg::queue_item_t   push_item,
    input  tpct_pkg::queue_status_t q_status
);
    import tpct_pkg::*;

    logic        hold_valid_reg;
    logic        hold_valid_next;
    queue_item_t hold_reg;
    queue_item_t hold_next;
    logic        take;

    assign push         = hold_valid_reg && !q_status.full;
    assign packet_ready = !hold_valid_reg || !q_status.full;
    assign take         = packet_valid && packet_ready;
    assign push_item    = hold_reg;

    always_comb
    begin
        hold_valid_next = (hold_valid_reg && !push) || take;
        hold_next       = hold_reg;
        if (take)
        begin
            hold_next.is_tcp         = (packet.ether_type == ETHERTYPE_IPV4) &&
                                       (packet.ip_protocol == PROTOCOL_TCP);
            hold_next.source_port    = packet.source_port;
            hold_next.dest_port      = packet.dest_port;
            hold_next.captured_bytes = packet.captured_bytes;
            hold_next.last_packet    = packet.last_packet;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_valid_reg <= 1'b0;
        end
        else
        begin
            hold_valid_reg <= hold_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hold_reg <= hold_next;
    end

endmodule

FILE: rtl/core/tpct_queue.sv
module tpct_queue #(
    parameter int QUEUE_DEPTH = tpct_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    push,
    input  tpct_pkg::queue_item_t   push_item,
    input  logic                    pop,
    output tpct_pkg::queue_item_t   head,
    output tpct_pkg::queue_status_t q_status
);
    import tpct_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    queue_item_t        slot_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_next;
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;
    logic               do_push;
    logic               do_pop;

    assign q_status.full  = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign q_status.empty = (count_reg == '0);
    assign do_push        = push && !q_status.full;
    assign do_pop         = pop && !q_status.empty;
    assign head           = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

FILE: rtl/core/tpct_engine.sv
module tpct_engine #(
    parameter int TABLE_ENTRIES = tpct_pkg::TABLE_ENTRIES_DEF
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  tpct_pkg::queue_item_t   head,
    input  tpct_pkg::queue_status_t q_status,
    output logic                    pop,
    output logic                    result_valid,
    input  logic                    result_ready,
    output tpct_pkg::result_t       result
);
    import tpct_pkg::*;

    localparam int IDX_W = $clog2(TABLE_ENTRIES);
    localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);

    entry_t             mem [TABLE_ENTRIES];
    entry_t             rd_data_reg;
    logic               mem_we;
    logic [IDX_W-1:0]   mem_waddr;
    entry_t             mem_wdata;

    state_t             state_reg;
    state_t             state_next;
    queue_item_t        item_reg;
    queue_item_t        item_next;
    logic [CNT_W-1:0]   scan_addr_reg;
    logic [CNT_W-1:0]   scan_addr_next;
    logic               chk_valid_reg;
    logic               chk_valid_next;
    logic [IDX_W-1:0]   chk_idx_reg;
    logic [IDX_W-1:0]   chk_idx_next;
    logic               found_reg;
    logic               found_next;
    logic [IDX_W-1:0]   match_idx_reg;
    logic [IDX_W-1:0]   match_idx_next;
    entry_t             upd_reg;
    entry_t             upd_next;
    logic [CNT_W-1:0]   used_reg;
    logic [CNT_W-1:0]   used_next;
    logic               out_valid_reg;
    logic               out_valid_next;
    result_t            out_reg;
    result_t            out_next;

    logic               issue;
    logic               hit;
    logic               out_free;
    logic               commit_go;
    logic [48:0]        byte_sum;

    assign issue     = (scan_addr_reg < used_reg);
    assign hit       = chk_valid_reg && rd_data_reg.is_tcp &&
                       ((rd_data_reg.src_port == item_reg.source_port) ||
                        (rd_data_reg.dst_port == item_reg.dest_port) ||
                        (rd_data_reg.src_port == item_reg.dest_port) ||
                        (rd_data_reg.dst_port == item_reg.source_port));
    assign out_free  = !out_valid_reg || result_ready;
    assign commit_go = (state_reg == ST_COMMIT) && out_free;
    assign byte_sum  = {1'b0, rd_data_reg.bytes} + 49'(item_reg.captured_bytes);

    assign result_valid = out_valid_reg;
    assign result       = out_reg;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (!q_status.empty)
                begin
                    state_next = (head.is_tcp && (used_reg != '0)) ? ST_SCAN : ST_COMMIT;
                end
            end
            ST_SCAN:
            begin
                if (hit || (chk_valid_reg && !issue))
                begin
                    state_next = ST_COMMIT;
                end
            end
            ST_COMMIT:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        pop            = 1'b0;
        item_next      = item_reg;
        scan_addr_next = scan_addr_reg;
        chk_valid_next = 1'b0;
        chk_idx_next   = chk_idx_reg;
        found_next     = found_reg;
        match_idx_next = match_idx_reg;
        upd_next       = upd_reg;
        used_next      = used_reg;
        out_valid_next = out_valid_reg && !result_ready;
        out_next       = out_reg;
        mem_we         = 1'b0;
        mem_waddr      = match_idx_reg;
        mem_wdata      = upd_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (!q_status.empty)
                begin
                    pop            = 1'b1;
                    item_next      = head;
                    scan_addr_next = '0;
                    found_next     = 1'b0;
                end
            end
            ST_SCAN:
            begin
                // one memory read a cycle, compare lands in the cycle after its read
                if (issue && !hit)
                begin
                    scan_addr_next = scan_addr_reg + 1'b1;
                    chk_valid_next = 1'b1;
                    chk_idx_next   = scan_addr_reg[IDX_W-1:0];
                end
                if (hit)
                begin
                    found_next       = 1'b1;
                    match_idx_next   = chk_idx_reg;
                    upd_next         = rd_data_reg;
                    upd_next.packets = (rd_data_reg.packets == PACKETS_MAX) ?
                                       PACKETS_MAX : rd_data_reg.packets + 32'd1;
                    upd_next.bytes   = byte_sum[48] ? BYTES_MAX : byte_sum[47:0];
                end
            end
            ST_COMMIT:
            begin
                if (out_free)
                begin
                    out_valid_next                  = 1'b1;
                    out_next.new_conversation       = 1'b0;
                    out_next.table_full             = 1'b0;
                    if (found_reg)
                    begin
                        mem_we                      = 1'b1;
                        out_next.conv_index         = 6'(match_idx_reg);
                        out_next.conv_packets       = upd_reg.packets;
                        out_next.conv_bytes         = upd_reg.bytes;
                        out_next.conversation_count = 7'(used_reg);
                    end
                    else if (used_reg < CNT_W'(TABLE_ENTRIES))
                    begin
                        mem_we                      = 1'b1;
                        mem_waddr                   = used_reg[IDX_W-1:0];
                        mem_wdata.is_tcp            = item_reg.is_tcp;
                        mem_wdata.src_port          = item_reg.source_port;
                        mem_wdata.dst_port          = item_reg.dest_port;
                        mem_wdata.packets           = 32'd1;
                        mem_wdata.bytes             = 48'(item_reg.captured_bytes);
                        used_next                   = used_reg + 1'b1;
                        out_next.conv_index         = 6'(used_reg);
                        out_next.new_conversation   = 1'b1;
                        out_next.conv_packets       = 32'd1;
                        out_next.conv_bytes         = 48'(item_reg.captured_bytes);
                        out_next.conversation_count = 7'(used_reg + 1'b1);
                    end
                    else
                    begin
                        out_next.conv_index         = '0;
                        out_next.table_full         = 1'b1;
                        out_next.conv_packets       = '0;
                        out_next.conv_bytes         = '0;
                        out_next.conversation_count = 7'(used_reg);
                    end
                    // end of capture empties the table
                    if (item_reg.last_packet)
                    begin
                        used_next = '0;
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            chk_valid_reg <= 1'b0;
            used_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            chk_valid_reg <= chk_valid_next;
            used_reg      <= used_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg      <= item_next;
        scan_addr_reg <= scan_addr_next;
        chk_idx_reg   <= chk_idx_next;
        found_reg     <= found_next;
        match_idx_reg <= match_idx_next;
        upd_reg       <= upd_next;
        out_reg       <= out_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        rd_data_reg <= mem[scan_addr_reg[IDX_W-1:0]];
    end

endmodule

FILE: rtl/core/tcp_port_conversation_table_unit.sv
// scan: a non-tcp packet or one that meets an empty table skips the table scan; a tcp packet
// reads stored entries in order until its first match, or every used entry with no match
// order: the engine takes one packet at a time, from queue pop to result, paced by the
// single-port table scan that reads one stored entry per cycle; the queue lets the next
// packet wait meanwhile
// reset: async active low; table count goes to zero, entries need no clearing pass
module tcp_port_conversation_table_unit #(
    parameter int TABLE_ENTRIES = tpct_pkg::TABLE_ENTRIES_DEF,
    parameter int QUEUE_DEPTH   = tpct_pkg::QUEUE_DEPTH_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              packet_valid,
    output logic              packet_ready,
    input  tpct_pkg::packet_t packet,
    output logic              result_valid,
    input  logic              result_ready,
    output tpct_pkg::result_t result
);
    import tpct_pkg::*;

    logic          push;
    queue_item_t   push_item;
    logic          pop;
    queue_item_t   head;
    queue_status_t q_status;

    tpct_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .packet_valid (packet_valid),
        .packet_ready (packet_ready),
        .packet       (packet),
        .push         (push),
        .push_item    (push_item),
        .q_status     (q_status)
    );

    tpct_queue #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .head      (head),
        .q_status  (q_status)
    );

    tpct_engine #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_engine (
        .clk          (clk),
        .rst_n        (rst_n),
        .head         (head),
        .q_status     (q_status),
        .pop          (pop),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

endmodule
